// ===== sv/sawbc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the set-associative write-back cache
// no dependencies

package sawbc_pkg;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_FILL  = 2'd2,
        KIND_NONE  = 2'd3
    } t_in_kind;

    typedef enum logic [1:0] {
        OUT_READ_DATA  = 2'd0,
        OUT_WRITE_DONE = 2'd1,
        OUT_WB_BEAT    = 2'd2,
        OUT_FILL_REQ   = 2'd3
    } t_out_kind;

    typedef struct packed {
        t_in_kind    kind;
        logic [31:0] addr;
        logic [31:0] write_data;
        logic [31:0] write_mask;
        logic [31:0] fill_word;
    } t_in;

    typedef struct packed {
        t_out_kind   out_kind;
        logic [31:0] out_data;
        logic [25:0] mem_block;
        logic [3:0]  beat;
        logic        last;
    } t_out;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        logic [15:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

// ===== sv/sawbc_way_ram.sv =====
`timescale 1ns / 1ps
// synchronous ram with one row per address and a write enable per way
// one write port and one read port, read data registered; no dependencies

module sawbc_way_ram #(
    parameter int ADDR_W = 4,
    parameter int WAYS   = 4,
    parameter int WIDTH  = 32
) (
    input  logic                        i_clk,
    input  logic [WAYS-1:0]             i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [WIDTH-1:0]            i_wdata,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [WAYS-1:0][WIDTH-1:0]  o_rdata
);

    logic [WAYS-1:0][WIDTH-1:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        for (int w = 0; w < WAYS; w++) begin
            if (i_we[w]) begin
                mem[i_waddr][w] <= i_wdata;
            end
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== sv/set_assoc_write_back_cache.sv =====
`timescale 1ns / 1ps
// set-associative write-back cache with random victim, top level; uses sawbc_pkg, sawbc_way_ram
// hit: the lookup state registers the result beat and returns to idle for the next start
// miss: a dirty victim is written back one beat per word before the fill request goes out
// fill words one a cycle; after the last one the answer passes the fill-read and finish states
// sequential, bound by the one read port of the tag and data rams; the receiver cannot stall
// synchronous active-low reset clears valid and dirty bits and loads the lfsr with 1

module set_assoc_write_back_cache #(
    parameter int ADDR_WIDTH    = 32,
    parameter int OFFSET_BITS   = 6,
    parameter int CAPACITY_BITS = 14,
    parameter int WAY_WIDTH     = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sawbc_pkg::t_in    i_cmd,
    output logic              o_result_valid,
    output sawbc_pkg::t_out   o_result,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data
);

    localparam int SET_W    = CAPACITY_BITS - OFFSET_BITS - WAY_WIDTH;
    localparam int SET_IW   = (SET_W > 0) ? SET_W : 1;
    localparam int WAY_IW   = (WAY_WIDTH > 0) ? WAY_WIDTH : 1;
    localparam int NUM_WAYS = 1 << WAY_WIDTH;
    localparam int NUM_SETS = 1 << SET_W;
    localparam int WI       = OFFSET_BITS - 2;
    localparam int WPL      = 1 << WI;
    localparam int TAG_W    = ADDR_WIDTH - OFFSET_BITS - SET_W;
    localparam int LINE_W   = SET_IW + WAY_IW;
    localparam int DADDR_W  = SET_IW + WI;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOKUP, S_WB, S_REQ, S_FILL_RD, S_FINISH
    } t_state;

    t_state               r_state;
    sawbc_pkg::t_in       r_item;
    logic [WAY_IW-1:0]    r_pa_way;
    logic                 r_miss;
    logic [WI-1:0]        r_fill_cnt;
    logic [WI-1:0]        r_beat;
    logic [15:0]          r_lfsr;
    logic [TAG_W-1:0]     r_vtag;
    logic [2**LINE_W-1:0] r_valid;
    logic [2**LINE_W-1:0] r_dirty;
    logic                 r_out_v;
    sawbc_pkg::t_out      r_out;

    logic [ADDR_WIDTH-1:0] a_i, a_r;
    logic [SET_IW-1:0]     set_i, set_r;
    logic [WI-1:0]         w_i, w_r;
    logic [TAG_W-1:0]      tag_r;

    logic [NUM_WAYS-1:0]              d_we, t_we;
    logic [DADDR_W-1:0]               d_waddr, d_raddr;
    logic [31:0]                      d_wdata;
    logic [SET_IW-1:0]                t_raddr;
    logic [NUM_WAYS-1:0][31:0]        d_row;
    logic [NUM_WAYS-1:0][TAG_W-1:0]   t_row;

    logic              hit;
    logic [WAY_IW-1:0] hit_way, fway, vway;
    logic [15:0]       lfsr_n;
    logic [31:0]       word, merged;
    logic              fill_acc, last_fill;

    function automatic sawbc_pkg::t_out make_out(sawbc_pkg::t_out_kind k, logic [31:0] d,
                                                 logic [25:0] blk, logic [3:0] b, logic l);
        sawbc_pkg::t_out r;
        r.out_kind  = k;
        r.out_data  = d;
        r.mem_block = blk;
        r.beat      = b;
        r.last      = l;
        return r;
    endfunction

    assign a_i   = ADDR_WIDTH'(i_cmd.addr);
    assign a_r   = ADDR_WIDTH'(r_item.addr);
    assign set_i = SET_IW'((a_i >> OFFSET_BITS) & ADDR_WIDTH'(NUM_SETS - 1));
    assign set_r = SET_IW'((a_r >> OFFSET_BITS) & ADDR_WIDTH'(NUM_SETS - 1));
    assign w_i   = a_i[OFFSET_BITS-1:2];
    assign w_r   = a_r[OFFSET_BITS-1:2];
    assign tag_r = TAG_W'(a_r >> (OFFSET_BITS + SET_W));

    assign busy      = (r_state != S_IDLE);
    assign fill_acc  = start && !busy && (i_cmd.kind == sawbc_pkg::KIND_FILL) && r_miss;
    assign last_fill = (r_fill_cnt == WI'(WPL - 1));

    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!hit && r_valid[{set_r, WAY_IW'(w)}] && t_row[w] == tag_r) begin
                hit     = 1'b1;
                hit_way = WAY_IW'(w);
            end
        end
    end

    assign lfsr_n = sawbc_pkg::lfsr_next(r_lfsr);
    assign vway   = WAY_IW'(lfsr_n & 16'(NUM_WAYS - 1));
    assign fway   = (r_state == S_FINISH) ? r_pa_way : hit_way;
    assign word   = d_row[fway];
    assign merged = (word & ~r_item.write_mask) | (r_item.write_data & r_item.write_mask);

    // ram addressing and write enables
    always_comb begin
        t_raddr = (r_state == S_IDLE) ? set_i : set_r;
        unique case (r_state)
            S_IDLE:   d_raddr = {set_i, w_i};
            S_LOOKUP: d_raddr = {set_r, WI'(0)};
            S_WB:     d_raddr = {set_r, WI'(r_beat + WI'(1))};
            default:  d_raddr = {set_r, w_r};
        endcase
        d_we    = '0;
        d_waddr = {set_r, w_r};
        d_wdata = merged;
        t_we    = '0;
        if (fill_acc) begin
            d_we[r_pa_way] = 1'b1;
            d_waddr        = {set_r, r_fill_cnt};
            d_wdata        = i_cmd.fill_word;
            t_we[r_pa_way] = last_fill;
        end else if (r_item.kind == sawbc_pkg::KIND_WRITE &&
                     ((r_state == S_LOOKUP && hit) || r_state == S_FINISH)) begin
            d_we[fway] = 1'b1;
        end
    end

    sawbc_way_ram #(.ADDR_W(DADDR_W), .WAYS(NUM_WAYS), .WIDTH(32)) u_data (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_row)
    );

    sawbc_way_ram #(.ADDR_W(SET_IW), .WAYS(NUM_WAYS), .WIDTH(TAG_W)) u_tag (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (set_r),
        .i_wdata (tag_r),
        .i_raddr (t_raddr),
        .o_rdata (t_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_miss     <= 1'b0;
            r_fill_cnt <= '0;
            r_beat     <= '0;
            r_lfsr     <= 16'd1;
            r_valid    <= '0;
            r_dirty    <= '0;
            r_out_v    <= 1'b0;
            r_out      <= '0;
            r_pa_way   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_lfsr <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_out_v <= 1'b0;
                    r_out   <= '0;
                    if (start && !r_miss && (i_cmd.kind == sawbc_pkg::KIND_READ ||
                                             i_cmd.kind == sawbc_pkg::KIND_WRITE)) begin
                        r_item  <= i_cmd;
                        r_state <= S_LOOKUP;
                    end else if (fill_acc) begin
                        if (last_fill) begin
                            r_fill_cnt                <= '0;
                            r_miss                    <= 1'b0;
                            r_valid[{set_r, r_pa_way}] <= 1'b1;
                            r_dirty[{set_r, r_pa_way}] <= 1'b0;
                            r_state                   <= S_FILL_RD;
                        end else begin
                            r_fill_cnt <= r_fill_cnt + WI'(1);
                        end
                    end
                end
                S_LOOKUP: begin
                    if (hit) begin
                        r_out_v <= 1'b1;
                        if (r_item.kind == sawbc_pkg::KIND_WRITE) begin
                            r_out <= make_out(sawbc_pkg::OUT_WRITE_DONE, 32'd0, 26'd0, 4'd0,
                                              1'b1);
                            r_dirty[{set_r, hit_way}] <= 1'b1;
                        end else begin
                            r_out <= make_out(sawbc_pkg::OUT_READ_DATA, word, 26'd0, 4'd0,
                                              1'b1);
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_lfsr                 <= lfsr_n;
                        r_pa_way               <= vway;
                        r_miss                 <= 1'b1;
                        r_fill_cnt             <= '0;
                        r_valid[{set_r, vway}] <= 1'b0;
                        r_dirty[{set_r, vway}] <= 1'b0;
                        r_vtag                 <= t_row[vway];
                        r_beat                 <= '0;
                        if (r_valid[{set_r, vway}] && r_dirty[{set_r, vway}]) begin
                            r_out_v <= 1'b0;
                            r_out   <= '0;
                            r_state <= S_WB;
                        end else begin
                            r_out_v <= 1'b1;
                            r_out   <= make_out(sawbc_pkg::OUT_FILL_REQ, 32'd0,
                                                26'(a_r >> OFFSET_BITS), 4'd0, 1'b1);
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_WB: begin
                    r_out_v <= 1'b1;
                    r_out   <= make_out(sawbc_pkg::OUT_WB_BEAT, d_row[r_pa_way],
                                        26'((ADDR_WIDTH'(r_vtag) << SET_W) |
                                            ADDR_WIDTH'(set_r)),
                                        4'(r_beat), 1'b0);
                    r_beat  <= r_beat + WI'(1);
                    if (r_beat == WI'(WPL - 1)) begin
                        r_state <= S_REQ;
                    end
                end
                S_REQ: begin
                    r_out_v <= 1'b1;
                    r_out   <= make_out(sawbc_pkg::OUT_FILL_REQ, 32'd0,
                                        26'(a_r >> OFFSET_BITS), 4'd0, 1'b1);
                    r_state <= S_IDLE;
                end
                S_FILL_RD: begin
                    r_out_v <= 1'b0;
                    r_out   <= '0;
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_out_v <= 1'b1;
                    if (r_item.kind == sawbc_pkg::KIND_WRITE) begin
                        r_out <= make_out(sawbc_pkg::OUT_WRITE_DONE, 32'd0, 26'd0, 4'd0,
                                          1'b1);
                        r_dirty[{set_r, r_pa_way}] <= 1'b1;
                    end else begin
                        r_out <= make_out(sawbc_pkg::OUT_READ_DATA, word, 26'd0, 4'd0,
                                          1'b1);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_out_v <= 1'b0;
                    r_out   <= '0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid = r_out_v;
    assign o_result       = r_out;

    a_wb_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.out_kind == sawbc_pkg::OUT_WB_BEAT |-> !r_out.last)
        else $error("write-back beat marked last");

    a_wb_in_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WB || r_state == S_REQ |-> r_miss)
        else $error("write-back without pending miss");

    a_fill_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_miss |-> r_fill_cnt == '0)
        else $error("fill count moved without a pending miss");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINISH |-> r_valid[{set_r, r_pa_way}])
        else $error("pending access finishes on an invalid line");

endmodule

// ===== verif/sawbc_checker.sv =====
`timescale 1ns / 1ps
// predictor and result checker for the set-associative write-back cache
// depends on sawbc_pkg; watches command, config and result channels of the block

module sawbc_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  sawbc_pkg::t_in  i_cmd,
    input  logic            o_result_valid,
    input  sawbc_pkg::t_out o_result,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data,
    output int              fail_count,
    output int              outstanding
);

    localparam int WORDS = 16;
    localparam int WAYS  = 4;

    logic [31:0]     cache_words [256*WORDS];
    logic [19:0]     cache_tags  [256];
    logic            cache_valid [256];
    logic            cache_dirty [256];
    logic [15:0]     victim_gen;
    logic            fill_wait;
    logic [3:0]      fill_pos;
    sawbc_pkg::t_in  held_access;
    logic [7:0]      held_line;
    sawbc_pkg::t_out answers_due [$];

    assign outstanding = answers_due.size();

    function automatic sawbc_pkg::t_out make_beat(sawbc_pkg::t_out_kind k, logic [31:0] d,
                                                  logic [25:0] blk, logic [3:0] b, logic l);
        sawbc_pkg::t_out r;
        r.out_kind  = k;
        r.out_data  = d;
        r.mem_block = blk;
        r.beat      = b;
        r.last      = l;
        return r;
    endfunction

    // completes a read or write on a valid line
    task automatic complete_access(sawbc_pkg::t_in a, logic [7:0] ln);
        int idx;
        idx = ln * WORDS + a.addr[5:2];
        if (a.kind == sawbc_pkg::KIND_WRITE) begin
            cache_words[idx] = (cache_words[idx] & ~a.write_mask) |
                               (a.write_data & a.write_mask);
            cache_dirty[ln] = 1'b1;
            answers_due.push_back(make_beat(sawbc_pkg::OUT_WRITE_DONE, '0, '0, '0, 1'b1));
        end else begin
            answers_due.push_back(make_beat(sawbc_pkg::OUT_READ_DATA, cache_words[idx],
                                            '0, '0, 1'b1));
        end
    endtask

    task automatic predict_cache(sawbc_pkg::t_in c);
        logic [5:0]  set;
        logic [7:0]  ln;
        logic        hit;
        if (c.kind == sawbc_pkg::KIND_FILL) begin
            if (fill_wait) begin
                cache_words[held_line * WORDS + fill_pos] = c.fill_word;
                if (fill_pos != 4'd15) begin
                    fill_pos = fill_pos + 1;
                end else begin
                    fill_pos = 0;
                    fill_wait = 1'b0;
                    cache_valid[held_line] = 1'b1;
                    cache_dirty[held_line] = 1'b0;
                    cache_tags[held_line]  = held_access.addr[31:12];
                    complete_access(held_access, held_line);
                end
            end
        end else if (c.kind != sawbc_pkg::KIND_NONE && !fill_wait) begin
            set = c.addr[11:6];
            hit = 1'b0;
            for (int w = 0; w < WAYS; w++) begin
                if (!hit && cache_valid[{set, w[1:0]}] &&
                    cache_tags[{set, w[1:0]}] == c.addr[31:12]) begin
                    hit = 1'b1;
                    complete_access(c, {set, w[1:0]});
                end
            end
            if (!hit) begin
                victim_gen = victim_gen[0] ? ((victim_gen >> 1) ^ 16'hB400)
                                           : (victim_gen >> 1);
                ln = {set, victim_gen[1:0]};
                if (cache_valid[ln] && cache_dirty[ln]) begin
                    for (int b = 0; b < WORDS; b++) begin
                        answers_due.push_back(make_beat(sawbc_pkg::OUT_WB_BEAT,
                            cache_words[ln * WORDS + b], {cache_tags[ln], set},
                            b[3:0], 1'b0));
                    end
                end
                cache_valid[ln] = 1'b0;
                cache_dirty[ln] = 1'b0;
                answers_due.push_back(make_beat(sawbc_pkg::OUT_FILL_REQ, '0, c.addr[31:6],
                                                '0, 1'b1));
                fill_wait   = 1'b1;
                fill_pos    = 0;
                held_access = c;
                held_line   = ln;
            end
        end
    endtask

    task automatic compare_beat(sawbc_pkg::t_out got);
        sawbc_pkg::t_out want;
        if (answers_due.size() == 0) begin
            $error("unexpected result beat: %p", got);
            fail_count++;
            return;
        end
        want = answers_due.pop_front();
        if (got.out_kind !== want.out_kind) begin
            $error("out_kind: expected %0d, actual %0d", want.out_kind, got.out_kind);
            fail_count++;
        end
        if (got.out_data !== want.out_data) begin
            $error("out_data: expected %h, actual %h", want.out_data, got.out_data);
            fail_count++;
        end
        if (got.mem_block !== want.mem_block) begin
            $error("mem_block: expected %h, actual %h", want.mem_block, got.mem_block);
            fail_count++;
        end
        if (got.beat !== want.beat) begin
            $error("beat: expected %0d, actual %0d", want.beat, got.beat);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 256; i++) begin
                cache_valid[i] = 1'b0;
                cache_dirty[i] = 1'b0;
            end
            victim_gen = 16'd1;
            fill_wait  = 1'b0;
            fill_pos   = 0;
            fail_count = 0;
            answers_due.delete();
        end else begin
            if (o_result_valid) begin
                compare_beat(o_result);
            end
            if (i_cfg_we) begin
                victim_gen = (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
            end
            if (start && !busy) begin
                predict_cache(i_cmd);
            end
        end
    end

endmodule

// ===== verif/set_assoc_write_back_cache_test.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the set-associative write-back cache
// depends on sawbc_pkg, set_assoc_write_back_cache and sawbc_checker

module set_assoc_write_back_cache_test;

    localparam int CYCLE_LIMIT = 1000000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    sawbc_pkg::t_in       i_cmd = '0;
    logic                 o_result_valid;
    sawbc_pkg::t_out      o_result;
    logic                 i_cfg_we = 1'b0;
    logic [15:0]          i_cfg_data = '0;
    int                   fail_count;
    int                   outstanding;
    int                   cycles = 0;
    int                   idle_pct = 0;
    sawbc_pkg::t_out_kind final_kind;

    set_assoc_write_back_cache dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    sawbc_checker scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // leaves start high after the accepting edge; callers lower it
    task automatic issue(sawbc_pkg::t_in c);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic await_answer();
        start <= 1'b0;
        do @(posedge i_clk); while (!(o_result_valid && o_result.last));
        final_kind = o_result.out_kind;
    endtask

    function automatic sawbc_pkg::t_in make_access(sawbc_pkg::t_in_kind k, logic [31:0] a);
        sawbc_pkg::t_in c;
        c.kind       = k;
        c.addr       = a;
        c.write_data = $urandom;
        c.write_mask = ($urandom_range(3) == 0) ? 32'hFFFFFFFF : $urandom;
        c.fill_word  = $urandom;
        return c;
    endfunction

    function automatic logic [31:0] pool_addr();
        logic [31:0] a;
        a = $urandom;
        if ($urandom_range(9) != 0) begin
            a[31:12] = ($urandom_range(1) == 0) ? 20'($urandom_range(5))
                                                 : 20'hFFFF8 + 20'($urandom_range(2));
            a[11:6]  = 6'($urandom_range(2));
        end
        return a;
    endfunction

    // one access; on a miss the block is filled, with some ignored noise mixed in
    task automatic run_access(sawbc_pkg::t_in c, bit noisy);
        sawbc_pkg::t_in f;
        await_answer_after(c);
        if (final_kind == sawbc_pkg::OUT_FILL_REQ) begin
            for (int i = 0; i < 16; i++) begin
                if (noisy && $urandom_range(7) == 0) begin
                    issue(make_access(sawbc_pkg::t_in_kind'($urandom_range(1)), $urandom));
                end
                f = make_access(sawbc_pkg::KIND_FILL, $urandom);
                issue(f);
            end
            await_answer();
        end
    endtask

    task automatic await_answer_after(sawbc_pkg::t_in c);
        issue(c);
        await_answer();
    endtask

    task automatic write_seed(logic [15:0] s);
        start <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        sawbc_pkg::t_in c;
        int             pick;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every kind, ignored items
        issue(make_access(sawbc_pkg::KIND_FILL, 32'hFFFFFFFF));
        issue(make_access(sawbc_pkg::KIND_NONE, 32'hFFFFFFFF));
        c = make_access(sawbc_pkg::KIND_WRITE, 32'h00000000);
        c.write_mask = 32'hFFFFFFFF;
        c.write_data = 32'hFFFFFFFF;
        run_access(c, 1'b1);
        c.write_mask = 32'h0;
        run_access(c, 1'b0);
        run_access(make_access(sawbc_pkg::KIND_READ, 32'h00000003), 1'b0);
        run_access(make_access(sawbc_pkg::KIND_READ, 32'hFFFFFFFF), 1'b1);
        c = make_access(sawbc_pkg::KIND_WRITE, 32'hFFFFFFFC);
        c.write_mask = 32'h0F0F0F0F;
        run_access(c, 1'b0);
        run_access(make_access(sawbc_pkg::KIND_READ, 32'hFFFFFFF8), 1'b0);
        issue(make_access(sawbc_pkg::KIND_NONE, 32'h0));
        start <= 1'b0;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_seed(16'hFFFF);
                1: write_seed(16'h0000);
                2: write_seed(16'h0001);
                default: write_seed(16'($urandom));
            endcase
            idle_pct = (ph == 1) ? 76 : (ph == 3) ? 24 : 0;
            for (int n = 0; n < 7; n++) begin
                pick = $urandom_range(19);
                if (pick == 0) begin
                    issue(make_access(sawbc_pkg::t_in_kind'($urandom_range(2, 3)), $urandom));
                end else begin
                    run_access(make_access(sawbc_pkg::t_in_kind'($urandom_range(1)),
                                           pool_addr()),
                               pick < 4);
                end
            end
        end
        start <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
